// File: hw/rtl/gmd_pkg.sv
// Shared types, defaults and the record hash of the glyph metric deduplicator.
`default_nettype none

package gmd_pkg;

  localparam int unsigned MaxUniqueDef   = 4096;
  localparam int unsigned HashBucketsDef = 1024;
  localparam int unsigned FieldW         = 16;

  typedef enum logic [2:0] {
    ST_BOOT_CLR,
    ST_IDLE,
    ST_SET_CLR,
    ST_HASH,
    ST_LOOKUP,
    ST_COMPARE
  } gmd_state_e;

  typedef enum logic [1:0] {
    RES_MATCH,
    RES_NEW,
    RES_FULL
  } gmd_res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;    // latch the request fields
    logic     count_clr;  // empty the set
    logic     clr_step;   // invalidate one bucket head
    logic     hash_en;    // register bucket and read its head
    logic     rd_head;    // read the entry the bucket head points at
    logic     rd_next;    // read the entry the chain link points at
    logic     finish;     // load the result, store on a new record
    gmd_res_e res;
  } gmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic head_valid;
    logic rec_match;
    logic next_valid;
    logic full;
  } gmd_sts_t;

  // Shift-and-add mix over sign-extended fields, sums mod 2^32.
  function automatic logic [31:0] hash_mix(
    input logic [FieldW-1:0] lb,
    input logic [FieldW-1:0] rb,
    input logic [FieldW-1:0] wd,
    input logic [FieldW-1:0] asc,
    input logic [FieldW-1:0] dsc,
    input logic [FieldW-1:0] attr
  );
    logic [31:0] lb32, rb32, wd32, as32, ds32, lb_asr, rb_asr, h;
    lb32   = {{16{lb[15]}}, lb};
    rb32   = {{16{rb[15]}}, rb};
    wd32   = {{16{wd[15]}}, wd};
    as32   = {{16{asc[15]}}, asc};
    ds32   = {{16{dsc[15]}}, dsc};
    lb_asr = {{5{lb32[31]}}, lb32[31:5]};
    rb_asr = {{9{rb32[31]}}, rb32[31:9]};
    h = (lb32 << 27) + lb_asr + (rb32 << 23) + rb_asr + (wd32 << 16)
      + (as32 << 11) + (ds32 << 6);
    return h ^ {16'b0, attr};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gmd_ctrl.sv
// Controller state machine: request intake, head clearing, chain walk, result hand-off.
`default_nettype none

module gmd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              start_new_set_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gmd_pkg::gmd_cmd_t      cmd_o,
  input  wire gmd_pkg::gmd_sts_t sts_i
);
  import gmd_pkg::*;

  gmd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BOOT_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res  = RES_MATCH;
    in_ready_o = 1'b0;
    case (state_q)
      ST_BOOT_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (start_new_set_i) begin
            cmd_o.count_clr = 1'b1;
            state_d         = ST_SET_CLR;
          end else begin
            state_d = ST_HASH;
          end
        end
      end
      ST_SET_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_HASH;
      end
      ST_HASH: begin
        cmd_o.hash_en = 1'b1;
        state_d       = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts_i.head_valid) begin
          cmd_o.rd_head = 1'b1;
          state_d       = ST_COMPARE;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = sts_i.full ? RES_FULL : RES_NEW;
          state_d      = ST_IDLE;
        end
      end
      ST_COMPARE: begin
        if (sts_i.rec_match) begin
          if (out_free) begin
            cmd_o.finish = 1'b1;
            cmd_o.res    = RES_MATCH;
            state_d      = ST_IDLE;
          end
        end else if (sts_i.next_valid) begin
          cmd_o.rd_next = 1'b1;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = sts_i.full ? RES_FULL : RES_NEW;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gmd_datapath.sv
// Datapath: request latch, hash, bucket head memory, record and chain memories, result register.
`default_nettype none

module gmd_datapath #(
  parameter int unsigned MAX_UNIQUE   = gmd_pkg::MaxUniqueDef,
  parameter int unsigned HASH_BUCKETS = gmd_pkg::HashBucketsDef,
  localparam int unsigned IdxW = $clog2(MAX_UNIQUE),
  localparam int unsigned CntW = $clog2(MAX_UNIQUE + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gmd_pkg::gmd_cmd_t        cmd_i,
  output gmd_pkg::gmd_sts_t             sts_o,
  input  wire logic signed [15:0]       left_bearing_i,
  input  wire logic signed [15:0]       right_bearing_i,
  input  wire logic signed [15:0]       char_width_i,
  input  wire logic signed [15:0]       ascent_value_i,
  input  wire logic signed [15:0]       descent_value_i,
  input  wire logic        [15:0]       attribute_bits_i,
  output logic             [IdxW-1:0]   unique_index_o,
  output logic                          is_new_o,
  output logic                          store_full_o,
  output logic             [CntW-1:0]   unique_total_o
);
  import gmd_pkg::*;

  localparam int unsigned BktW = $clog2(HASH_BUCKETS);
  localparam int unsigned PtrW = IdxW + 1;

  // Request latch: fields packed as the stored words.
  logic [63:0]     lo_q;
  logic [31:0]     hi_q;
  logic [31:0]     hash;
  logic [BktW-1:0] bucket_q;

  // Bucket heads: valid bit over index.
  logic [PtrW-1:0] head_mem [HASH_BUCKETS];
  logic [PtrW-1:0] head_q;
  logic [BktW-1:0] clr_q;

  logic [63:0]     rec_lo_mem [MAX_UNIQUE];
  logic [31:0]     rec_hi_mem [MAX_UNIQUE];
  logic [PtrW-1:0] chain_mem  [MAX_UNIQUE];
  logic [63:0]     rec_lo_q;
  logic [31:0]     rec_hi_q;
  logic [PtrW-1:0] chain_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [IdxW-1:0] rd_addr;

  logic [CntW-1:0] count_q;
  logic            full;
  logic            do_insert;
  logic [IdxW-1:0] wr_idx;

  logic [IdxW-1:0] out_idx_q;
  logic            out_new_q;
  logic            out_full_q;
  logic [CntW-1:0] out_total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lo_q <= {ascent_value_i, char_width_i, right_bearing_i, left_bearing_i};
      hi_q <= {attribute_bits_i, descent_value_i};
    end
  end

  assign hash = hash_mix(lo_q[15:0], lo_q[31:16], lo_q[47:32], lo_q[63:48],
                         hi_q[15:0], hi_q[31:16]);

  // Register bucket and read its head in the same cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_en) begin
      bucket_q <= hash[BktW-1:0];
      head_q   <= head_mem[hash[BktW-1:0]];
    end
  end

  assign full      = count_q >= CntW'(MAX_UNIQUE);
  assign do_insert = cmd_i.finish && (cmd_i.res == RES_NEW);
  assign wr_idx    = count_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      head_mem[clr_q] <= '0;
    end else if (do_insert) begin
      head_mem[bucket_q] <= {1'b1, wr_idx};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + BktW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.count_clr) begin
      count_q <= '0;
    end else if (do_insert) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // Push the new record at the head of its chain.
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      rec_lo_mem[wr_idx] <= lo_q;
      rec_hi_mem[wr_idx] <= hi_q;
      chain_mem[wr_idx]  <= head_q;
    end
  end

  assign rd_addr = cmd_i.rd_head ? head_q[IdxW-1:0] : chain_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_head || cmd_i.rd_next) begin
      rec_lo_q <= rec_lo_mem[rd_addr];
      rec_hi_q <= rec_hi_mem[rd_addr];
      chain_q  <= chain_mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      case (cmd_i.res)
        RES_MATCH: begin
          out_idx_q   <= rd_idx_q;
          out_new_q   <= 1'b0;
          out_full_q  <= 1'b0;
          out_total_q <= count_q;
        end
        RES_NEW: begin
          out_idx_q   <= wr_idx;
          out_new_q   <= 1'b1;
          out_full_q  <= 1'b0;
          out_total_q <= count_q + CntW'(1);
        end
        default: begin
          out_idx_q   <= '0;
          out_new_q   <= 1'b0;
          out_full_q  <= 1'b1;
          out_total_q <= count_q;
        end
      endcase
    end
  end

  assign sts_o.clr_last   = clr_q == BktW'(HASH_BUCKETS - 1);
  assign sts_o.head_valid = head_q[IdxW];
  assign sts_o.rec_match  = (rec_lo_q == lo_q) && (rec_hi_q == hi_q);
  assign sts_o.next_valid = chain_q[IdxW];
  assign sts_o.full       = full;

  assign unique_index_o = out_idx_q;
  assign is_new_o       = out_new_q;
  assign store_full_o   = out_full_q;
  assign unique_total_o = out_total_q;

endmodule

`default_nettype wire

// File: hw/rtl/glyph_metric_dedup.sv
// Top level of the glyph metric deduplicator: controller plus datapath.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, six record fields | request in
//   out     | out_valid_o/out_ready_i, four results    | result out
//
// An item passes through intake, hashing, the bucket head lookup and one compare per
// chain entry before the next acceptance; each compare is one record memory read.
// A request with start_new_set_i set first clears the bucket head memory,
// one head per cycle; the same pass runs after reset.
// A result waits in the output register while the next request is accepted;
// the walk holds only when it has a result and that register is still full.
`default_nettype none

module glyph_metric_dedup #(
  parameter int unsigned MAX_UNIQUE   = gmd_pkg::MaxUniqueDef,
  parameter int unsigned HASH_BUCKETS = gmd_pkg::HashBucketsDef,
  localparam int unsigned IdxW = $clog2(MAX_UNIQUE),
  localparam int unsigned CntW = $clog2(MAX_UNIQUE + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   start_new_set_i,
  input  wire logic signed [15:0]     left_bearing_i,
  input  wire logic signed [15:0]     right_bearing_i,
  input  wire logic signed [15:0]     char_width_i,
  input  wire logic signed [15:0]     ascent_value_i,
  input  wire logic signed [15:0]     descent_value_i,
  input  wire logic        [15:0]     attribute_bits_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic             [IdxW-1:0] unique_index_o,
  output logic                        is_new_o,
  output logic                        store_full_o,
  output logic             [CntW-1:0] unique_total_o
);
  import gmd_pkg::*;

  gmd_cmd_t cmd;
  gmd_sts_t sts;

  gmd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_new_set_i(start_new_set_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  gmd_datapath #(
    .MAX_UNIQUE  (MAX_UNIQUE),
    .HASH_BUCKETS(HASH_BUCKETS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .left_bearing_i  (left_bearing_i),
    .right_bearing_i (right_bearing_i),
    .char_width_i    (char_width_i),
    .ascent_value_i  (ascent_value_i),
    .descent_value_i (descent_value_i),
    .attribute_bits_i(attribute_bits_i),
    .unique_index_o  (unique_index_o),
    .is_new_o        (is_new_o),
    .store_full_o    (store_full_o),
    .unique_total_o  (unique_total_o)
  );

`ifndef SYNTHESIS
  a_new_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && store_full_o))
    else $error("result flagged both new and full");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unique_total_o <= CntW'(MAX_UNIQUE)))
    else $error("unique total beyond store size");

  a_new_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_new_o) |-> ({1'b0, unique_index_o} == unique_total_o - CntW'(1)))
    else $error("new record index is not the last stored entry");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && store_full_o) |-> (unique_total_o == CntW'(MAX_UNIQUE)))
    else $error("store full reported below capacity");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_glyph_metric_dedup.sv
// Testbench for glyph_metric_dedup: directed and random glyph records checked against a predictor.
module tb_glyph_metric_dedup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCnt   = gmd_pkg::MaxUniqueDef;
  localparam int unsigned BucketCnt = gmd_pkg::HashBucketsDef;
  localparam int unsigned IdxW      = $clog2(SlotCnt);
  localparam int unsigned CntW      = $clog2(SlotCnt + 1);
  localparam int unsigned PoolMax   = 48;

  typedef struct packed {
    logic [15:0] lb;
    logic [15:0] rb;
    logic [15:0] wd;
    logic [15:0] asc;
    logic [15:0] dsc;
    logic [15:0] attr;
  } glyph_rec_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            is_new;
    logic            full;
    logic [CntW-1:0] total;
  } dedup_res_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              start_new_set_i;
  logic [15:0]       left_bearing_i;
  logic [15:0]       right_bearing_i;
  logic [15:0]       char_width_i;
  logic [15:0]       ascent_value_i;
  logic [15:0]       descent_value_i;
  logic [15:0]       attribute_bits_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [IdxW-1:0]   unique_index_o;
  logic              is_new_o;
  logic              store_full_o;
  logic [CntW-1:0]   unique_total_o;

  glyph_metric_dedup u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_new_set_i  (start_new_set_i),
    .left_bearing_i   (left_bearing_i),
    .right_bearing_i  (right_bearing_i),
    .char_width_i     (char_width_i),
    .ascent_value_i   (ascent_value_i),
    .descent_value_i  (descent_value_i),
    .attribute_bits_i (attribute_bits_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .unique_index_o   (unique_index_o),
    .is_new_o         (is_new_o),
    .store_full_o     (store_full_o),
    .unique_total_o   (unique_total_o)
  );

  // Predictor copy of the table: records, chain links and bucket heads ({valid, index}).
  glyph_rec_t    seen_rec   [SlotCnt];
  logic [IdxW:0] seen_link  [SlotCnt];
  logic [IdxW:0] bucket_top [BucketCnt];
  int unsigned   seen_count;

  dedup_res_t res_queue[$];
  glyph_rec_t rec_pool[$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors    = 0;
  int n_sent    = 0;
  int n_new     = 0;
  int n_match   = 0;
  int n_full    = 0;
  int n_restart = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("glyph_metric_dedup test failed");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Keep the sum in signed ints so the right shifts stay arithmetic.
  function automatic logic [31:0] glyph_hash(glyph_rec_t r);
    int lb, rb, wd, ac, dc, h;
    lb = int'($signed(r.lb));
    rb = int'($signed(r.rb));
    wd = int'($signed(r.wd));
    ac = int'($signed(r.asc));
    dc = int'($signed(r.dsc));
    h  = (lb << 27) + (lb >>> 5) + (rb << 23) + (rb >>> 9) + (wd << 16)
       + (ac << 11) + (dc << 6);
    return 32'(h) ^ {16'h0000, r.attr};
  endfunction

  // Look the record up, store it if new, and return the result the block must give.
  function automatic dedup_res_t dedup_lookup(glyph_rec_t r, logic restart);
    dedup_res_t  res;
    int unsigned b;
    int unsigned idx;
    int unsigned steps;
    logic        found;
    res   = '0;
    found = 1'b0;
    if (restart) begin
      foreach (bucket_top[i]) bucket_top[i] = '0;
      seen_count = 0;
    end
    b = glyph_hash(r) % BucketCnt;
    if (bucket_top[b][IdxW]) begin
      idx = 32'(bucket_top[b][IdxW-1:0]);
      for (steps = 0; steps < seen_count; steps++) begin
        if (seen_rec[idx] == r) begin
          found     = 1'b1;
          res.index = IdxW'(idx);
          break;
        end
        if (!seen_link[idx][IdxW]) break;
        idx = 32'(seen_link[idx][IdxW-1:0]);
      end
    end
    if (!found) begin
      if (seen_count >= SlotCnt) begin
        res.full = 1'b1;
      end else begin
        seen_rec[seen_count]  = r;
        seen_link[seen_count] = bucket_top[b];
        bucket_top[b]         = {1'b1, IdxW'(seen_count)};
        res.index             = IdxW'(seen_count);
        res.is_new            = 1'b1;
        seen_count++;
      end
    end
    res.total = CntW'(seen_count);
    return res;
  endfunction

  always @(posedge clk_i) begin : check_results
    dedup_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (res_queue.size() == 0) begin
        $display("%0t: result with none expected: index %0d new %0b full %0b total %0d",
                 $time, unique_index_o, is_new_o, store_full_o, unique_total_o);
        errors++;
      end else begin
        want = res_queue.pop_front();
        if (unique_index_o !== want.index) begin
          $display("%0t: unique_index expected %0d got %0d", $time, want.index, unique_index_o);
          errors++;
        end
        if (is_new_o !== want.is_new) begin
          $display("%0t: is_new expected %0b got %0b", $time, want.is_new, is_new_o);
          errors++;
        end
        if (store_full_o !== want.full) begin
          $display("%0t: store_full expected %0b got %0b", $time, want.full, store_full_o);
          errors++;
        end
        if (unique_total_o !== want.total) begin
          $display("%0t: unique_total expected %0d got %0d", $time, want.total, unique_total_o);
          errors++;
        end
        if (want.is_new) n_new++;
        else if (want.full) n_full++;
        else n_match++;
      end
    end
  end

  // Entered and left at a falling edge; valid stays high after the request is taken.
  task automatic send_glyph(glyph_rec_t r, logic restart);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    start_new_set_i  <= restart;
    left_bearing_i   <= r.lb;
    right_bearing_i  <= r.rb;
    char_width_i     <= r.wd;
    ascent_value_i   <= r.asc;
    descent_value_i  <= r.dsc;
    attribute_bits_i <= r.attr;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res_queue.push_back(dedup_lookup(r, restart));
    n_sent++;
    if (restart) n_restart++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (res_queue.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return $urandom_range(1) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic glyph_rec_t rand_glyph();
    glyph_rec_t r;
    r.lb   = pick_field();
    r.rb   = pick_field();
    r.wd   = pick_field();
    r.asc  = pick_field();
    r.dsc  = pick_field();
    r.attr = pick_field();
    return r;
  endfunction

  task automatic test_field_extremes();
    send_idle = 0;
    recv_idle = 0;
    send_glyph('0, 1'b1);
    send_glyph({6{16'hffff}}, 1'b0);
    send_glyph({{5{16'h8000}}, 16'h0000}, 1'b0);
    send_glyph({{5{16'h7fff}}, 16'hffff}, 1'b0);
    send_glyph({{3{16'h5555, 16'haaaa}}}, 1'b0);
    send_glyph({{3{16'haaaa, 16'h5555}}}, 1'b0);
    // repeat a few to hit the match path
    send_glyph('0, 1'b0);
    send_glyph({6{16'hffff}}, 1'b0);
    send_glyph({{5{16'h8000}}, 16'h0000}, 1'b0);
  endtask

  // Flipping attr[15:10] or moving descent by 16 keeps the bucket, so these records chain.
  task automatic test_bucket_chain();
    glyph_rec_t base;
    glyph_rec_t r;
    int         k;
    base = rand_glyph();
    for (k = 0; k < 6; k++) begin
      r = base;
      r.attr[15:10] = base.attr[15:10] ^ 6'(k * 11);
      send_glyph(r, 1'b0);
    end
    r = base;
    r.dsc = base.dsc + 16'd16;
    send_glyph(r, 1'b0);
    for (k = 5; k >= 0; k--) begin
      r = base;
      r.attr[15:10] = base.attr[15:10] ^ 6'(k * 11);
      send_glyph(r, 1'b0);
    end
  endtask

  task automatic test_start_flag();
    glyph_rec_t r;
    r = rand_glyph();
    send_glyph(r, 1'b0);
    send_glyph(r, 1'b1);
    send_glyph(r, 1'b0);
    send_glyph(rand_glyph(), 1'b1);
  endtask

  task automatic test_store_full();
    glyph_rec_t  r;
    glyph_rec_t  keep;
    int unsigned k;
    keep = '0;
    // distinct left bearings make every record distinct, so none matches an earlier one
    for (k = 0; k < SlotCnt + 3; k++) begin
      r    = rand_glyph();
      r.lb = 16'(k);
      send_glyph(r, k == 0);
      if (k == 5) keep = r;
    end
    send_glyph(keep, 1'b0);
    wait_drained();
    send_glyph(rand_glyph(), 1'b1);
  endtask

  task automatic test_random_mix(int n, int s_idle, int r_idle);
    glyph_rec_t r;
    int         pick;
    logic       restart;
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) begin
      restart = 1'b0;
      if ($urandom_range(99) < 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 3) begin
        restart = 1'b1;
        rec_pool.delete();
        r = rand_glyph();
      end else if (pick < 40 && rec_pool.size() != 0) begin
        r = rec_pool[$urandom_range(rec_pool.size() - 1)];
      end else if (pick < 65 && rec_pool.size() != 0) begin
        r = rec_pool[$urandom_range(rec_pool.size() - 1)];
        r.attr[15:10] = r.attr[15:10] ^ 6'($urandom_range(63, 1));
      end else begin
        r = rand_glyph();
      end
      send_glyph(r, restart);
      rec_pool.push_back(r);
      if (rec_pool.size() > PoolMax) void'(rec_pool.pop_front());
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    start_new_set_i  = 1'b0;
    left_bearing_i   = '0;
    right_bearing_i  = '0;
    char_width_i     = '0;
    ascent_value_i   = '0;
    descent_value_i  = '0;
    attribute_bits_i = '0;
    foreach (bucket_top[i]) bucket_top[i] = '0;
    seen_count = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_bucket_chain();
    test_start_flag();
    test_store_full();
    wait_drained();
    test_random_mix(185, 21, 74);
    test_random_mix(185, 74, 21);
    test_random_mix(180, 0, 0);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d glyph records, %0d of them with a set restart.", n_sent, n_restart);
    $display("Results: %0d stored as new, %0d matched, %0d refused on a full store.",
             n_new, n_match, n_full);
    if (errors == 0) begin
      $display("glyph_metric_dedup test passed");
    end else begin
      $display("glyph_metric_dedup test failed");
    end
    $finish;
  end

endmodule
